/* design/tkd_pkg.sv */
// ----------------------------------------------------------------------------
// Terminal key sequence decoder package
// Shared types, codes and defaults for the terminal key decoder.
// ----------------------------------------------------------------------------
package tkd_pkg;

  // Default depth of the CSI parameter byte store.
  localparam int unsigned PARAM_DEPTH_DEF = 16;

  // Number of spaces for a tab after reset.
  localparam logic [3:0] TAB_SPACES_RESET = 4'd4;

  // Byte codes used by the decoder.
  localparam logic [7:0] BYTE_ESC       = 8'h1b;
  localparam logic [7:0] BYTE_DEL       = 8'h7f;
  localparam logic [7:0] BYTE_BS        = 8'h08;
  localparam logic [7:0] BYTE_CR        = 8'h0d;
  localparam logic [7:0] BYTE_LF        = 8'h0a;
  localparam logic [7:0] BYTE_TAB       = 8'h09;
  localparam logic [7:0] BYTE_SPACE     = 8'h20;
  localparam logic [7:0] BYTE_PARAM_MAX = 8'h3f;
  localparam logic [7:0] BYTE_SEMI      = 8'h3b;
  localparam logic [7:0] BYTE_FIVE      = 8'h35;
  localparam logic [7:0] BYTE_CSI_INTRO = 8'h5b;
  localparam logic [7:0] BYTE_SS3_INTRO = 8'h4f;
  localparam logic [7:0] BYTE_TILDE     = 8'h7e;

  // Key event codes.
  typedef enum logic [4:0] {
    KEY_NONE      = 5'd0,
    KEY_CHAR      = 5'd1,
    KEY_ENTER     = 5'd2,
    KEY_BACKSPACE = 5'd3,
    KEY_INTERRUPT = 5'd4,
    KEY_EOF       = 5'd5,
    KEY_HOME      = 5'd6,
    KEY_END       = 5'd7,
    KEY_LEFT      = 5'd8,
    KEY_RIGHT     = 5'd9,
    KEY_UP        = 5'd10,
    KEY_DOWN      = 5'd11,
    KEY_WORDLEFT  = 5'd12,
    KEY_WORDRIGHT = 5'd13,
    KEY_DELETE    = 5'd14,
    KEY_KILLSTART = 5'd15,
    KEY_KILLEND   = 5'd16,
    KEY_KILLWORD  = 5'd17,
    KEY_CLEAR     = 5'd18,
    KEY_IGNORED   = 5'd19
  } key_code_e;

  // Decoder modes.
  typedef enum logic [2:0] {
    MODE_GROUND = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_CSI    = 3'd2,
    MODE_SS3    = 3'd3,
    MODE_UTF8   = 3'd4
  } mode_e;

  // Mode and UTF-8 collection state.
  typedef struct packed {
    mode_e       mode;
    logic [23:0] collected;
    logic [1:0]  count;
    logic [1:0]  owed;
  } dec_state_t;

  // One key event.
  typedef struct packed {
    key_code_e   key;
    logic [63:0] text;
    logic [3:0]  len;
  } result_t;

endpackage

/* design/tkd_decode.sv */
// ----------------------------------------------------------------------------
// Terminal key decoder step logic
// Maps one byte and the current decoder state to a key event and next state.
// ----------------------------------------------------------------------------
module tkd_decode #(
  parameter int unsigned PARAM_DEPTH = tkd_pkg::PARAM_DEPTH_DEF,
  localparam int unsigned CW = $clog2(PARAM_DEPTH + 1)
) (
  input  logic [7:0]           byte_i,
  input  logic [3:0]           tab_spaces_i,
  input  tkd_pkg::dec_state_t  state_i,
  input  logic [CW-1:0]        param_count_i,
  input  logic [7:0]           param_i [PARAM_DEPTH],
  output tkd_pkg::dec_state_t  state_o,
  output logic [CW-1:0]        param_count_o,
  output logic                 param_we_o,
  output tkd_pkg::result_t     result_o
);

  typedef struct packed {
    tkd_pkg::result_t    res;
    tkd_pkg::dec_state_t st;
  } ground_t;

  localparam tkd_pkg::dec_state_t STATE_CLEAR = '{
    mode: tkd_pkg::MODE_GROUND, collected: 24'd0, count: 2'd0, owed: 2'd0};

  // Build a result with no text.
  function automatic tkd_pkg::result_t plain_key(input tkd_pkg::key_code_e k);
    tkd_pkg::result_t r;
    r.key  = k;
    r.text = 64'd0;
    r.len  = 4'd0;
    return r;
  endfunction

  // Handling of one byte in ground mode, starting from a cleared state.
  function automatic ground_t ground_fn(input logic [7:0] b, input logic [3:0] tw);
    ground_t    g;
    logic [3:0] n;
    g.st  = STATE_CLEAR;
    g.res = plain_key(tkd_pkg::KEY_IGNORED);
    case (b)
      tkd_pkg::BYTE_ESC: begin
        g.st.mode = tkd_pkg::MODE_ESCAPE;
        g.res     = plain_key(tkd_pkg::KEY_NONE);
      end
      tkd_pkg::BYTE_CR, tkd_pkg::BYTE_LF: g.res = plain_key(tkd_pkg::KEY_ENTER);
      tkd_pkg::BYTE_DEL, tkd_pkg::BYTE_BS: g.res = plain_key(tkd_pkg::KEY_BACKSPACE);
      8'h03: g.res = plain_key(tkd_pkg::KEY_INTERRUPT);
      8'h04: g.res = plain_key(tkd_pkg::KEY_EOF);
      8'h01: g.res = plain_key(tkd_pkg::KEY_HOME);
      8'h05: g.res = plain_key(tkd_pkg::KEY_END);
      8'h02: g.res = plain_key(tkd_pkg::KEY_LEFT);
      8'h06: g.res = plain_key(tkd_pkg::KEY_RIGHT);
      8'h10: g.res = plain_key(tkd_pkg::KEY_UP);
      8'h0e: g.res = plain_key(tkd_pkg::KEY_DOWN);
      8'h15: g.res = plain_key(tkd_pkg::KEY_KILLSTART);
      8'h0b: g.res = plain_key(tkd_pkg::KEY_KILLEND);
      8'h17: g.res = plain_key(tkd_pkg::KEY_KILLWORD);
      8'h0c: g.res = plain_key(tkd_pkg::KEY_CLEAR);
      tkd_pkg::BYTE_TAB: begin
        // Clamp the width to one through eight spaces.
        if (tw == 4'd0) begin
          n = 4'd1;
        end else if (tw > 4'd8) begin
          n = 4'd8;
        end else begin
          n = tw;
        end
        g.res.key = tkd_pkg::KEY_CHAR;
        g.res.len = n;
        for (int i = 0; i < 8; i++) begin
          g.res.text[8*i +: 8] = (4'(i) < n) ? tkd_pkg::BYTE_SPACE : 8'h00;
        end
      end
      default: begin
        if (b < tkd_pkg::BYTE_SPACE) begin
          g.res = plain_key(tkd_pkg::KEY_IGNORED);
        end else if (!b[7]) begin
          g.res.key  = tkd_pkg::KEY_CHAR;
          g.res.text = {56'd0, b};
          g.res.len  = 4'd1;
        end else if ((b & 8'hE0) == 8'hC0 || (b & 8'hF0) == 8'hE0 ||
                     (b & 8'hF8) == 8'hF0) begin
          // UTF-8 lead byte: start collecting the character.
          g.st.mode      = tkd_pkg::MODE_UTF8;
          g.st.collected = {16'd0, b};
          g.st.count     = 2'd1;
          if ((b & 8'hE0) == 8'hC0) begin
            g.st.owed = 2'd1;
          end else if ((b & 8'hF0) == 8'hE0) begin
            g.st.owed = 2'd2;
          end else begin
            g.st.owed = 2'd3;
          end
          g.res = plain_key(tkd_pkg::KEY_NONE);
        end else begin
          g.res = plain_key(tkd_pkg::KEY_IGNORED);
        end
      end
    endcase
    return g;
  endfunction

  ground_t              ground;
  logic                 ctrl;
  logic                 one_number;
  tkd_pkg::key_code_e   final_key;
  logic [63:0]          utf_text;

  assign ground = ground_fn(byte_i, tab_spaces_i);

  // A ";5" pair anywhere among the stored parameters marks ctrl.
  always_comb begin
    ctrl = 1'b0;
    for (int i = 0; i + 1 < PARAM_DEPTH; i++) begin
      if (CW'(i + 1) < param_count_i && param_i[i] == tkd_pkg::BYTE_SEMI &&
          param_i[i + 1] == tkd_pkg::BYTE_FIVE) begin
        ctrl = 1'b1;
      end
    end
  end

  // The number before the first ';' is exactly one byte long.
  assign one_number = (param_count_i != '0) && (param_i[0] != tkd_pkg::BYTE_SEMI) &&
                      ((param_count_i == CW'(1)) || (param_i[1] == tkd_pkg::BYTE_SEMI));

  // Final byte of a CSI or SS3 sequence.
  always_comb begin
    case (byte_i)
      8'h41: final_key = tkd_pkg::KEY_UP;
      8'h42: final_key = tkd_pkg::KEY_DOWN;
      8'h43: final_key = ctrl ? tkd_pkg::KEY_WORDRIGHT : tkd_pkg::KEY_RIGHT;
      8'h44: final_key = ctrl ? tkd_pkg::KEY_WORDLEFT : tkd_pkg::KEY_LEFT;
      8'h48: final_key = tkd_pkg::KEY_HOME;
      8'h46: final_key = tkd_pkg::KEY_END;
      tkd_pkg::BYTE_TILDE: begin
        final_key = tkd_pkg::KEY_IGNORED;
        if (one_number) begin
          case (param_i[0])
            8'h31, 8'h37: final_key = tkd_pkg::KEY_HOME;
            8'h34, 8'h38: final_key = tkd_pkg::KEY_END;
            8'h33:        final_key = tkd_pkg::KEY_DELETE;
            default:      final_key = tkd_pkg::KEY_IGNORED;
          endcase
        end
      end
      default: final_key = tkd_pkg::KEY_IGNORED;
    endcase
  end

  // Collected bytes with the current byte placed after them.
  always_comb begin
    case (state_i.count)
      2'd0:    utf_text = {40'd0, state_i.collected[23:8], byte_i};
      2'd1:    utf_text = {40'd0, state_i.collected[23:16], byte_i,
                           state_i.collected[7:0]};
      2'd2:    utf_text = {40'd0, byte_i, state_i.collected[15:0]};
      default: utf_text = {32'd0, byte_i, state_i.collected};
    endcase
  end

  // Mode dispatch.
  always_comb begin
    state_o       = state_i;
    param_count_o = param_count_i;
    param_we_o    = 1'b0;
    result_o      = plain_key(tkd_pkg::KEY_NONE);
    case (state_i.mode)
      tkd_pkg::MODE_GROUND: begin
        state_o  = ground.st;
        result_o = ground.res;
      end
      tkd_pkg::MODE_UTF8: begin
        if (byte_i[7:6] != 2'b10) begin
          // Bad continuation: drop the partial character and start over.
          state_o       = ground.st;
          param_count_o = '0;
          result_o      = ground.res;
        end else if (state_i.owed <= 2'd1) begin
          state_o       = STATE_CLEAR;
          result_o.key  = tkd_pkg::KEY_CHAR;
          result_o.text = utf_text;
          result_o.len  = {2'b00, state_i.count} + 4'd1;
        end else begin
          state_o.collected = utf_text[23:0];
          state_o.count     = state_i.count + 2'd1;
          state_o.owed      = state_i.owed - 2'd1;
        end
      end
      tkd_pkg::MODE_ESCAPE: begin
        param_count_o = '0;
        if (byte_i == tkd_pkg::BYTE_CSI_INTRO) begin
          state_o.mode = tkd_pkg::MODE_CSI;
        end else if (byte_i == tkd_pkg::BYTE_SS3_INTRO) begin
          state_o.mode = tkd_pkg::MODE_SS3;
        end else begin
          state_o.mode = tkd_pkg::MODE_GROUND;
          if (byte_i == 8'h62 || byte_i == 8'h42) begin
            result_o = plain_key(tkd_pkg::KEY_WORDLEFT);
          end else if (byte_i == 8'h66 || byte_i == 8'h46) begin
            result_o = plain_key(tkd_pkg::KEY_WORDRIGHT);
          end else begin
            result_o = plain_key(tkd_pkg::KEY_IGNORED);
          end
        end
      end
      tkd_pkg::MODE_CSI: begin
        if (byte_i >= tkd_pkg::BYTE_SPACE && byte_i <= tkd_pkg::BYTE_PARAM_MAX) begin
          // Keep the parameter byte while there is room.
          if (param_count_i < CW'(PARAM_DEPTH)) begin
            param_we_o    = 1'b1;
            param_count_o = param_count_i + CW'(1);
          end
        end else begin
          state_o.mode = tkd_pkg::MODE_GROUND;
          result_o     = plain_key(final_key);
        end
      end
      tkd_pkg::MODE_SS3: begin
        state_o.mode = tkd_pkg::MODE_GROUND;
        result_o     = plain_key(final_key);
      end
      default: begin
        state_o       = STATE_CLEAR;
        param_count_o = '0;
        result_o      = plain_key(tkd_pkg::KEY_IGNORED);
      end
    endcase
  end

endmodule

/* design/terminal_key_sequence_decoder_core.sv */
// ----------------------------------------------------------------------------
// Terminal key sequence decoder
// Turns a stream of terminal input bytes into one key event per byte.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one key event on the master side, in
// order. The block takes one byte per clock cycle while the key event stream
// is not stalled; a byte is captured in an input register at acceptance and
// then decoded into a result register once that register is free or drains,
// from which its event is presented. The single decode step between those
// registers sets that rate. The tab width register may be written only
// while no bytes are in flight.
module terminal_key_sequence_decoder_core #(
  parameter int unsigned PARAM_DEPTH = tkd_pkg::PARAM_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: tab width.
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  // Input byte stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // Key event stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] text_bytes, [67:64] text_length, rest zero
  output logic [4:0]  m_axis_tuser    // [4:0] key_code
);

  localparam int unsigned CW = $clog2(PARAM_DEPTH + 1);
  localparam int unsigned IW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;

  logic [3:0]          tab_spaces_q;
  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                out_valid_q;
  tkd_pkg::result_t    out_res_q;
  tkd_pkg::dec_state_t state_q, state_d;
  logic [CW-1:0]       param_count_q, param_count_d;
  logic [7:0]          param_q [PARAM_DEPTH];
  logic                param_we;
  tkd_pkg::result_t    res_d;
  logic                advance;

  // The held byte moves on when the result register is free or drains.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_spaces_q <= tkd_pkg::TAB_SPACES_RESET;
    end else if (cfg_we_i) begin
      tab_spaces_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // Decode step.
  tkd_decode #(
    .PARAM_DEPTH(PARAM_DEPTH)
  ) u_decode (
    .byte_i       (in_byte_q),
    .tab_spaces_i (tab_spaces_q),
    .state_i      (state_q),
    .param_count_i(param_count_q),
    .param_i      (param_q),
    .state_o      (state_d),
    .param_count_o(param_count_d),
    .param_we_o   (param_we),
    .result_o     (res_d)
  );

  // Decoder state, updated once per transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode      <= tkd_pkg::MODE_GROUND;
      state_q.collected <= 24'd0;
      state_q.count     <= 2'd0;
      state_q.owed      <= 2'd0;
      param_count_q     <= '0;
    end else if (advance) begin
      state_q       <= state_d;
      param_count_q <= param_count_d;
    end
  end

  // Parameter byte store.
  always_ff @(posedge clk_i) begin
    if (advance && param_we) begin
      param_q[param_count_q[IW-1:0]] <= in_byte_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_res_q.len, out_res_q.text};
  assign m_axis_tuser  = out_res_q.key;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal key sequence decoder testbench
// Streams terminal bytes into the decoder and checks every key event it
// returns against a cycle-free predictor of the decode rules. The run
// covers plain bytes, control keys, tab expansion at several tab widths,
// UTF-8 characters (whole and broken), and escape, CSI and SS3 sequences,
// including parameter overflow. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned PARAM_DEPTH  = tkd_pkg::PARAM_DEPTH_DEF;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_BYTES  = 103;

  // Control bytes with a key of their own.
  localparam logic [7:0] CH_CTRL_A = 8'h01;
  localparam logic [7:0] CH_CTRL_B = 8'h02;
  localparam logic [7:0] CH_CTRL_C = 8'h03;
  localparam logic [7:0] CH_CTRL_D = 8'h04;
  localparam logic [7:0] CH_CTRL_E = 8'h05;
  localparam logic [7:0] CH_CTRL_F = 8'h06;
  localparam logic [7:0] CH_CTRL_K = 8'h0b;
  localparam logic [7:0] CH_CTRL_L = 8'h0c;
  localparam logic [7:0] CH_CTRL_N = 8'h0e;
  localparam logic [7:0] CH_CTRL_P = 8'h10;
  localparam logic [7:0] CH_CTRL_U = 8'h15;
  localparam logic [7:0] CH_CTRL_W = 8'h17;

  // Final bytes of CSI and SS3 sequences.
  localparam logic [7:0] FIN_UP    = 8'h41;
  localparam logic [7:0] FIN_DOWN  = 8'h42;
  localparam logic [7:0] FIN_RIGHT = 8'h43;
  localparam logic [7:0] FIN_LEFT  = 8'h44;
  localparam logic [7:0] FIN_END   = 8'h46;
  localparam logic [7:0] FIN_HOME  = 8'h48;

  // Bytes after ESC that give word moves.
  localparam logic [7:0] ALT_B_LOWER = 8'h62;
  localparam logic [7:0] ALT_B_UPPER = 8'h42;
  localparam logic [7:0] ALT_F_LOWER = 8'h66;
  localparam logic [7:0] ALT_F_UPPER = 8'h46;

  // Digits that select a key before '~'.
  localparam logic [7:0] DIGIT_ZERO  = 8'h30;
  localparam logic [7:0] DIGIT_ONE   = 8'h31;
  localparam logic [7:0] DIGIT_THREE = 8'h33;
  localparam logic [7:0] DIGIT_FOUR  = 8'h34;
  localparam logic [7:0] DIGIT_SEVEN = 8'h37;
  localparam logic [7:0] DIGIT_EIGHT = 8'h38;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [3:0]  cfg_wdata_i   = 4'd0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [71:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;

  terminal_key_sequence_decoder_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: mode, partial UTF-8 character, CSI parameters, tab width.
  tkd_pkg::mode_e dec_mode   = tkd_pkg::MODE_GROUND;
  logic [23:0]    utf8_bytes = '0;
  logic [1:0]     utf8_count = '0;
  logic [1:0]     utf8_owed  = '0;
  logic [7:0]     csi_params [PARAM_DEPTH];
  int unsigned    csi_count  = 0;
  logic [3:0]     tab_spaces = tkd_pkg::TAB_SPACES_RESET;

  // Stimulus and scoreboard storage.
  logic [7:0]       pending_bytes [$];
  tkd_pkg::result_t expected_events [$];
  logic [7:0]       csi_finals [7] = '{FIN_UP, FIN_DOWN, FIN_RIGHT, FIN_LEFT,
                                       FIN_HOME, FIN_END, tkd_pkg::BYTE_TILDE};
  int unsigned bytes_pushed_total = 0;
  int unsigned bytes_taken_count  = 0;
  int unsigned events_checked     = 0;
  int unsigned mismatch_count     = 0;
  int unsigned cycle_count        = 0;
  bit          key_hit [20];
  bit          idle_on            = 1'b1;
  bit          byte_taken         = 1'b0;
  int unsigned send_gap           = 0;
  int unsigned sink_gap           = 0;

  // Drop any partial character and sequence, back to ground mode.
  function automatic void restart_decoder();
    dec_mode   = tkd_pkg::MODE_GROUND;
    utf8_bytes = '0;
    utf8_count = '0;
    utf8_owed  = '0;
    csi_count  = 0;
  endfunction

  // Key event for a byte seen in ground mode.
  function automatic tkd_pkg::result_t ground_key(input logic [7:0] b);
    tkd_pkg::result_t ev;
    int unsigned      spaces;
    ev = '0;
    ev.key = tkd_pkg::KEY_IGNORED;
    case (b)
      tkd_pkg::BYTE_ESC: begin
        dec_mode = tkd_pkg::MODE_ESCAPE;
        ev.key   = tkd_pkg::KEY_NONE;
      end
      tkd_pkg::BYTE_CR, tkd_pkg::BYTE_LF:  ev.key = tkd_pkg::KEY_ENTER;
      tkd_pkg::BYTE_DEL, tkd_pkg::BYTE_BS: ev.key = tkd_pkg::KEY_BACKSPACE;
      CH_CTRL_C:         ev.key = tkd_pkg::KEY_INTERRUPT;
      CH_CTRL_D:         ev.key = tkd_pkg::KEY_EOF;
      CH_CTRL_A:         ev.key = tkd_pkg::KEY_HOME;
      CH_CTRL_E:         ev.key = tkd_pkg::KEY_END;
      CH_CTRL_B:         ev.key = tkd_pkg::KEY_LEFT;
      CH_CTRL_F:         ev.key = tkd_pkg::KEY_RIGHT;
      CH_CTRL_P:         ev.key = tkd_pkg::KEY_UP;
      CH_CTRL_N:         ev.key = tkd_pkg::KEY_DOWN;
      CH_CTRL_U:         ev.key = tkd_pkg::KEY_KILLSTART;
      CH_CTRL_K:         ev.key = tkd_pkg::KEY_KILLEND;
      CH_CTRL_W:         ev.key = tkd_pkg::KEY_KILLWORD;
      CH_CTRL_L:         ev.key = tkd_pkg::KEY_CLEAR;
      tkd_pkg::BYTE_TAB: begin
        // Tab width is clamped to 1..8 spaces.
        spaces = (tab_spaces < 4'd1) ? 1 : (tab_spaces > 4'd8) ? 8 : tab_spaces;
        ev.key = tkd_pkg::KEY_CHAR;
        for (int i = 0; i < spaces; i++) ev.text[8*i +: 8] = tkd_pkg::BYTE_SPACE;
        ev.len = 4'(spaces);
      end
      default: begin
        if (b < tkd_pkg::BYTE_SPACE) begin
          ev.key = tkd_pkg::KEY_IGNORED;
        end else if (b[7] == 1'b0) begin
          ev.key  = tkd_pkg::KEY_CHAR;
          ev.text = {56'd0, b};
          ev.len  = 4'd1;
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
          // UTF-8 lead byte: collect the rest of the character.
          utf8_bytes = {16'd0, b};
          utf8_count = 2'd1;
          utf8_owed  = (b[7:5] == 3'b110) ? 2'd1 : (b[7:4] == 4'b1110) ? 2'd2 : 2'd3;
          dec_mode   = tkd_pkg::MODE_UTF8;
          ev.key     = tkd_pkg::KEY_NONE;
        end else begin
          ev.key = tkd_pkg::KEY_IGNORED;
        end
      end
    endcase
    return ev;
  endfunction

  // Key for the final byte of a CSI or SS3 sequence.
  function automatic tkd_pkg::key_code_e final_key(input logic [7:0] b);
    int unsigned held;
    int unsigned num_len;
    bit          ctrl_mod;
    held     = (csi_count > PARAM_DEPTH) ? PARAM_DEPTH : csi_count;
    ctrl_mod = 1'b0;
    for (int i = 0; i + 1 < held; i++) begin
      if (csi_params[i] == tkd_pkg::BYTE_SEMI && csi_params[i+1] == tkd_pkg::BYTE_FIVE) begin
        ctrl_mod = 1'b1;
      end
    end
    case (b)
      FIN_UP:     return tkd_pkg::KEY_UP;
      FIN_DOWN:   return tkd_pkg::KEY_DOWN;
      FIN_RIGHT:  return ctrl_mod ? tkd_pkg::KEY_WORDRIGHT : tkd_pkg::KEY_RIGHT;
      FIN_LEFT:   return ctrl_mod ? tkd_pkg::KEY_WORDLEFT : tkd_pkg::KEY_LEFT;
      FIN_HOME:   return tkd_pkg::KEY_HOME;
      FIN_END:    return tkd_pkg::KEY_END;
      tkd_pkg::BYTE_TILDE: ;
      default:    return tkd_pkg::KEY_IGNORED;
    endcase
    // A single digit before the first ';' selects the key for '~'.
    num_len = 0;
    while (num_len < held && csi_params[num_len] != tkd_pkg::BYTE_SEMI) num_len++;
    if (num_len != 1) return tkd_pkg::KEY_IGNORED;
    case (csi_params[0])
      DIGIT_ONE, DIGIT_SEVEN:  return tkd_pkg::KEY_HOME;
      DIGIT_FOUR, DIGIT_EIGHT: return tkd_pkg::KEY_END;
      DIGIT_THREE:             return tkd_pkg::KEY_DELETE;
      default:                 return tkd_pkg::KEY_IGNORED;
    endcase
  endfunction

  // Expected key event for one accepted byte; advances the predictor state.
  function automatic tkd_pkg::result_t decode_byte(input logic [7:0] b);
    tkd_pkg::result_t ev;
    ev = '0;
    ev.key = tkd_pkg::KEY_NONE;
    case (dec_mode)
      tkd_pkg::MODE_GROUND: ev = ground_key(b);
      tkd_pkg::MODE_UTF8: begin
        if (b[7:6] != 2'b10) begin
          // Broken character: drop it and treat the byte as fresh input.
          restart_decoder();
          ev = ground_key(b);
        end else if (utf8_owed <= 2'd1) begin
          ev.key     = tkd_pkg::KEY_CHAR;
          ev.text    = {40'd0, utf8_bytes} | (64'(b) << (8 * utf8_count));
          ev.len     = 4'(utf8_count) + 4'd1;
          utf8_bytes = '0;
          utf8_count = '0;
          utf8_owed  = '0;
          dec_mode   = tkd_pkg::MODE_GROUND;
        end else begin
          utf8_bytes = utf8_bytes | (24'(b) << (8 * utf8_count));
          utf8_count = utf8_count + 2'd1;
          utf8_owed  = utf8_owed - 2'd1;
        end
      end
      tkd_pkg::MODE_ESCAPE: begin
        csi_count = 0;
        if (b == tkd_pkg::BYTE_CSI_INTRO) begin
          dec_mode = tkd_pkg::MODE_CSI;
        end else if (b == tkd_pkg::BYTE_SS3_INTRO) begin
          dec_mode = tkd_pkg::MODE_SS3;
        end else begin
          dec_mode = tkd_pkg::MODE_GROUND;
          if (b == ALT_B_LOWER || b == ALT_B_UPPER) ev.key = tkd_pkg::KEY_WORDLEFT;
          else if (b == ALT_F_LOWER || b == ALT_F_UPPER) ev.key = tkd_pkg::KEY_WORDRIGHT;
          else ev.key = tkd_pkg::KEY_IGNORED;
        end
      end
      tkd_pkg::MODE_CSI: begin
        if (b >= tkd_pkg::BYTE_SPACE && b <= tkd_pkg::BYTE_PARAM_MAX) begin
          // Parameter bytes past the store depth are dropped.
          if (csi_count < PARAM_DEPTH) begin
            csi_params[csi_count] = b;
            csi_count++;
          end
        end else begin
          dec_mode = tkd_pkg::MODE_GROUND;
          ev.key   = final_key(b);
        end
      end
      tkd_pkg::MODE_SS3: begin
        dec_mode = tkd_pkg::MODE_GROUND;
        ev.key   = final_key(b);
      end
      default: begin
        restart_decoder();
        ev.key = tkd_pkg::KEY_IGNORED;
      end
    endcase
    return ev;
  endfunction

  task automatic note_failure(input string msg);
    if (mismatch_count < 10) $display("[%0t] ERROR: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      note_failure($sformatf("event %0d %s expected 0x%0h got 0x%0h",
                             events_checked, name, want_v, got_v));
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_pushed_total++;
  endtask

  // One random input sequence: mostly well-formed keys with random content.
  task automatic push_random_sequence();
    int unsigned pick;
    int unsigned n;
    int unsigned break_at;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // CSI sequence, sometimes with more parameters than the store holds.
      push_byte(tkd_pkg::BYTE_ESC);
      push_byte(tkd_pkg::BYTE_CSI_INTRO);
      case ($urandom_range(0, 4))
        0: ;
        1: push_byte(DIGIT_ZERO + 8'($urandom_range(0, 9)));
        2: begin
          push_byte(DIGIT_ZERO + 8'($urandom_range(0, 9)));
          push_byte(tkd_pkg::BYTE_SEMI);
          push_byte($urandom_range(0, 2) != 0 ? tkd_pkg::BYTE_FIVE
                                              : DIGIT_ZERO + 8'($urandom_range(0, 9)));
        end
        3: begin
          repeat ($urandom_range(1, 6)) begin
            push_byte(8'($urandom_range(tkd_pkg::BYTE_SPACE, tkd_pkg::BYTE_PARAM_MAX)));
          end
        end
        default: begin
          n        = $urandom_range(14, 20);
          break_at = $urandom_range(0, 2 * n);
          for (int i = 0; i < n; i++) begin
            if (i == break_at) begin
              push_byte(tkd_pkg::BYTE_SEMI);
              push_byte(tkd_pkg::BYTE_FIVE);
            end else begin
              push_byte(8'($urandom_range(tkd_pkg::BYTE_SPACE, tkd_pkg::BYTE_PARAM_MAX)));
            end
          end
        end
      endcase
      if ($urandom_range(0, 9) < 8) push_byte(csi_finals[$urandom_range(0, 6)]);
      else push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 40) begin
      // SS3 sequence.
      push_byte(tkd_pkg::BYTE_ESC);
      push_byte(tkd_pkg::BYTE_SS3_INTRO);
      if ($urandom_range(0, 9) < 8) push_byte(csi_finals[$urandom_range(0, 6)]);
      else push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 50) begin
      // Alt word moves, or ESC followed by anything.
      push_byte(tkd_pkg::BYTE_ESC);
      case ($urandom_range(0, 5))
        0: push_byte(ALT_B_LOWER);
        1: push_byte(ALT_B_UPPER);
        2: push_byte(ALT_F_LOWER);
        3: push_byte(ALT_F_UPPER);
        default: push_byte(8'($urandom_range(0, 255)));
      endcase
    end else if (pick < 70) begin
      // UTF-8 character of 2 to 4 bytes, now and then broken.
      n        = $urandom_range(2, 4);
      break_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n - 1) : 0;
      case (n)
        2: push_byte({3'b110, 5'($urandom)});
        3: push_byte({4'b1110, 4'($urandom)});
        default: push_byte({5'b11110, 3'($urandom)});
      endcase
      for (int i = 1; i < n; i++) begin
        if (i == break_at) begin
          b = 8'($urandom_range(0, 255));
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          push_byte(b);
        end else begin
          push_byte({2'b10, 6'($urandom)});
        end
      end
    end else if (pick < 80) begin
      // Control bytes, tab included often.
      if ($urandom_range(0, 3) == 0) push_byte(tkd_pkg::BYTE_TAB);
      else push_byte(8'($urandom_range(0, 31)));
    end else if (pick < 90) begin
      push_byte(8'($urandom_range(tkd_pkg::BYTE_SPACE, tkd_pkg::BYTE_DEL)));
    end else begin
      push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic write_tab_spaces(input logic [3:0] width);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= width;
    tab_spaces = width;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every pushed byte has been taken and every event checked.
  task automatic wait_until_drained();
    do @(negedge clk_i);
    while (bytes_taken_count != bytes_pushed_total || expected_events.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Sender: present the next byte and hold it until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !byte_taken)) begin
      if (idle_on && send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (pending_bytes.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_bytes.pop_front();
        if (idle_on && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 10);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: ready most of the time, with random stall bursts.
  always @(negedge clk_i) begin
    if (idle_on && sink_gap > 0) begin
      m_axis_tready <= 1'b0;
      sink_gap      <= sink_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 5) == 0) sink_gap <= $urandom_range(1, 10);
    end
  end

  // Monitor: predict on each input transaction, check each output transaction.
  always @(posedge clk_i) begin : monitor
    tkd_pkg::result_t want;
    if (rst_ni) begin
      byte_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_events.push_back(decode_byte(s_axis_tdata));
        bytes_taken_count++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_events.size() == 0) begin
          note_failure($sformatf("key event with none expected: key %0d tdata 0x%0h",
                                 m_axis_tuser, m_axis_tdata));
        end else begin
          want = expected_events.pop_front();
          check_field("key_code", want.key, m_axis_tuser);
          check_field("text_bytes", want.text, m_axis_tdata[63:0]);
          check_field("text_length", want.len, m_axis_tdata[67:64]);
          check_field("tdata padding", 64'd0, m_axis_tdata[71:68]);
          key_hit[want.key] = 1'b1;
          events_checked++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d events outstanding.",
               cycle_count, expected_events.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus: directed bytes, then random phases at different tab widths.
  initial begin : stimulus
    logic [7:0]  warmup [28];
    int unsigned phase_goal;
    int unsigned keys_seen;
    warmup = '{8'h00, 8'hff, tkd_pkg::BYTE_DEL, tkd_pkg::BYTE_TAB, tkd_pkg::BYTE_CR,
               CH_CTRL_C, CH_CTRL_D, CH_CTRL_U, CH_CTRL_K, CH_CTRL_W, CH_CTRL_L,
               tkd_pkg::BYTE_ESC, tkd_pkg::BYTE_CSI_INTRO, DIGIT_ONE,
               tkd_pkg::BYTE_SEMI, tkd_pkg::BYTE_FIVE, FIN_RIGHT,
               tkd_pkg::BYTE_ESC, tkd_pkg::BYTE_SS3_INTRO, FIN_HOME,
               tkd_pkg::BYTE_ESC, tkd_pkg::BYTE_CSI_INTRO, DIGIT_THREE,
               tkd_pkg::BYTE_TILDE,
               8'hc3, 8'ha9, 8'he2, 8'h41};
    restart_decoder();
    tab_spaces = tkd_pkg::TAB_SPACES_RESET;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (warmup[i]) push_byte(warmup[i]);
    phase_goal = bytes_pushed_total;
    for (int p = 0; p < PHASES; p++) begin
      // Tab width changes only while the decoder is empty.
      if (p > 0) begin
        wait_until_drained();
        case (p)
          1: write_tab_spaces(4'd0);
          2: write_tab_spaces(4'd15);
          3: write_tab_spaces(4'd1);
          4: write_tab_spaces(4'd8);
          default: write_tab_spaces(4'($urandom_range(0, 15)));
        endcase
      end
      idle_on    = (p != PHASES - 1);
      phase_goal = phase_goal + PHASE_BYTES;
      while (bytes_pushed_total < phase_goal) push_random_sequence();
    end
    wait_until_drained();

    keys_seen = 0;
    foreach (key_hit[k]) keys_seen += key_hit[k];
    $display("Decoded %0d bytes over %0d tab width settings, %0d key events checked.",
             bytes_taken_count, PHASES, events_checked);
    $display("Key codes reached: %0d of 20; mismatches: %0d.", keys_seen, mismatch_count);
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
